FILE: rtl/cpu8asb_pkg.sv
// ----------------------------------------------------------------------------
// cpu8asb_pkg: codes and helpers for the 8-bit ALU, shift and bit unit
// Operation group, sub-operation codes, flag bit positions and the byte
// shifter shared by the prefixed shifts and the accumulator rotates.
// ----------------------------------------------------------------------------
package cpu8asb_pkg;

	// operation group
	typedef enum logic [2:0] {
		REQ_ALU   = 3'd0,
		REQ_SHIFT = 3'd1,
		REQ_BIT   = 3'd2,
		REQ_RES   = 3'd3,
		REQ_SET   = 3'd4,
		REQ_ROT_A = 3'd5,
		REQ_MISC  = 3'd6
	} req_type_t;

	// accumulator ALU operations
	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_ADC = 3'd1,
		ALU_SUB = 3'd2,
		ALU_SBC = 3'd3,
		ALU_AND = 3'd4,
		ALU_XOR = 3'd5,
		ALU_OR  = 3'd6,
		ALU_CP  = 3'd7
	} alu_op_t;

	// shift and rotate kinds; the accumulator rotates use the first four
	typedef enum logic [2:0] {
		SH_RLC  = 3'd0,
		SH_RRC  = 3'd1,
		SH_RL   = 3'd2,
		SH_RR   = 3'd3,
		SH_SLA  = 3'd4,
		SH_SRA  = 3'd5,
		SH_SWAP = 3'd6,
		SH_SRL  = 3'd7
	} shift_kind_t;

	// flag and complement operations
	typedef enum logic [2:0] {
		MISC_CPL = 3'd0,
		MISC_SCF = 3'd1,
		MISC_CCF = 3'd2
	} misc_op_t;

	// flag positions in the packed flag word
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	// returns {carry out, shifted byte}
	function automatic logic [8:0] shift_byte(input shift_kind_t kind,
		input logic [7:0] v, input logic cin);
		logic [8:0] r;
		begin
			case (kind)
				SH_RLC:  r = {v[7], v[6:0], v[7]};
				SH_RRC:  r = {v[0], v[0], v[7:1]};
				SH_RL:   r = {v[7], v[6:0], cin};
				SH_RR:   r = {v[0], cin, v[7:1]};
				SH_SLA:  r = {v[7], v[6:0], 1'b0};
				SH_SRA:  r = {v[0], v[7], v[7:1]};
				SH_SWAP: r = {1'b0, v[3:0], v[7:4]};
				SH_SRL:  r = {v[0], 1'b0, v[7:1]};
				default: r = {1'b0, v};
			endcase
			return r;
		end
	endfunction

endpackage

FILE: rtl/cpu8_alu_shift_bit_unit.sv
// ----------------------------------------------------------------------------
// cpu8_alu_shift_bit_unit: pipelined 8-bit ALU, shift and bit unit
// Accumulator ALU ops, prefixed shifts/rotates, bit test/reset/set,
// accumulator rotates and cpl/scf/ccf, with Z/N/H/C flag generation.
// ----------------------------------------------------------------------------
// Usage
//   Input: a word is taken at a rising edge where start is high and busy is
//   low. busy is held low: the pipe never stalls, so a word may be issued on
//   every cycle. Fields: req_type, sub_op, acc_value, operand_value, flags_in
//   (Z bit 3, N bit 2, H bit 1, C bit 0).
//   Output: each word yields exactly one result word, shown on result_value,
//   write_enable and flags_out for one cycle with done high. The receiver
//   cannot hold results off and needs none: there is no back pressure.
//   Pipeline: three register stages; done, result_value, write_enable and
//   flags_out come straight from the s3 registers.
//   Throughput: one word per cycle, as every stage moves on at every edge.
//   Stages: s1 registers the request; s2 holds the byte result, write enable
//   and N/H/C plus the byte whose zero-ness gives Z; s3 does the zero test
//   and registers the outputs.
//   Reset: arst_n clears the valid bits at once; words in flight are dropped
//   and done stays low until a new word has gone through.
// ----------------------------------------------------------------------------
module cpu8_alu_shift_bit_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] req_type,
	input  logic [2:0] sub_op,
	input  logic [7:0] acc_value,
	input  logic [7:0] operand_value,
	input  logic [3:0] flags_in,
	output logic       done,
	output logic [7:0] result_value,
	output logic       write_enable,
	output logic [3:0] flags_out
);

	// ---------------- stage 1: request register ----------------
	logic                   vld_s1;
	cpu8asb_pkg::req_type_t type_s1;
	logic [2:0]             sub_s1;
	logic [7:0]             acc_s1;
	logic [7:0]             opv_s1;
	logic [3:0]             fin_s1;

	// no back pressure anywhere in the pipe
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			type_s1 <= cpu8asb_pkg::req_type_t'(req_type);
			sub_s1  <= sub_op;
			acc_s1  <= acc_value;
			opv_s1  <= operand_value;
			fin_s1  <= flags_in;
		end
	end

	// ---------------- stage 2: compute ----------------
	// Z is either a zero test of ztest or a fixed value (kept or forced).
	logic [7:0] res_c;
	logic       we_c;
	logic       n_c;
	logic       h_c;
	logic       c_c;
	logic [7:0] ztest_c;
	logic       zuse_c;
	logic       zfix_c;

	logic       cin_c;
	logic       ci_c;
	logic [8:0] sum_c;
	logic [4:0] hsum_c;
	logic [8:0] dif_c;
	logic [4:0] hdif_c;
	logic [7:0] mask_c;
	logic [8:0] sh_c;
	logic [8:0] rot_c;

	assign cin_c = fin_s1[cpu8asb_pkg::FLAG_C];
	// carry in only for adc and sbc
	assign ci_c  = ((sub_s1 == cpu8asb_pkg::ALU_ADC) || (sub_s1 == cpu8asb_pkg::ALU_SBC))
		? cin_c : 1'b0;

	assign sum_c  = {1'b0, acc_s1} + {1'b0, opv_s1} + {8'd0, ci_c};
	assign hsum_c = {1'b0, acc_s1[3:0]} + {1'b0, opv_s1[3:0]} + {4'd0, ci_c};
	// bit 8 / bit 4 of the wrapped difference is the borrow
	assign dif_c  = {1'b0, acc_s1} - {1'b0, opv_s1} - {8'd0, ci_c};
	assign hdif_c = {1'b0, acc_s1[3:0]} - {1'b0, opv_s1[3:0]} - {4'd0, ci_c};

	assign mask_c = 8'd1 << sub_s1;

	assign sh_c  = cpu8asb_pkg::shift_byte(cpu8asb_pkg::shift_kind_t'(sub_s1),
		opv_s1, cin_c);
	// accumulator rotates use only the low two bits of the kind
	assign rot_c = cpu8asb_pkg::shift_byte(
		cpu8asb_pkg::shift_kind_t'({1'b0, sub_s1[1:0]}), acc_s1, cin_c);

	always_comb begin
		// default: no operation, flags kept
		res_c   = acc_s1;
		we_c    = 1'b0;
		n_c     = fin_s1[cpu8asb_pkg::FLAG_N];
		h_c     = fin_s1[cpu8asb_pkg::FLAG_H];
		c_c     = cin_c;
		ztest_c = 8'd0;
		zuse_c  = 1'b0;
		zfix_c  = fin_s1[cpu8asb_pkg::FLAG_Z];
		case (type_s1)
			cpu8asb_pkg::REQ_ALU: begin
				we_c   = 1'b1;
				n_c    = 1'b0;
				h_c    = 1'b0;
				c_c    = 1'b0;
				zuse_c = 1'b1;
				case (cpu8asb_pkg::alu_op_t'(sub_s1))
					cpu8asb_pkg::ALU_ADD,
					cpu8asb_pkg::ALU_ADC: begin
						ztest_c = sum_c[7:0];
						res_c   = sum_c[7:0];
						h_c     = hsum_c[4];
						c_c     = sum_c[8];
					end
					cpu8asb_pkg::ALU_SUB,
					cpu8asb_pkg::ALU_SBC: begin
						ztest_c = dif_c[7:0];
						res_c   = dif_c[7:0];
						n_c     = 1'b1;
						h_c     = hdif_c[4];
						c_c     = dif_c[8];
					end
					cpu8asb_pkg::ALU_CP: begin
						// flags of the subtraction, accumulator untouched
						ztest_c = dif_c[7:0];
						res_c   = acc_s1;
						we_c    = 1'b0;
						n_c     = 1'b1;
						h_c     = hdif_c[4];
						c_c     = dif_c[8];
					end
					cpu8asb_pkg::ALU_AND: begin
						ztest_c = acc_s1 & opv_s1;
						res_c   = acc_s1 & opv_s1;
						h_c     = 1'b1;
					end
					cpu8asb_pkg::ALU_XOR: begin
						ztest_c = acc_s1 ^ opv_s1;
						res_c   = acc_s1 ^ opv_s1;
					end
					default: begin
						ztest_c = acc_s1 | opv_s1;
						res_c   = acc_s1 | opv_s1;
					end
				endcase
			end
			cpu8asb_pkg::REQ_SHIFT: begin
				res_c   = sh_c[7:0];
				ztest_c = sh_c[7:0];
				zuse_c  = 1'b1;
				we_c    = 1'b1;
				n_c     = 1'b0;
				h_c     = 1'b0;
				c_c     = sh_c[8];
			end
			cpu8asb_pkg::REQ_BIT: begin
				// Z is the complement of the tested bit
				res_c   = opv_s1;
				ztest_c = opv_s1 & mask_c;
				zuse_c  = 1'b1;
				n_c     = 1'b0;
				h_c     = 1'b1;
			end
			cpu8asb_pkg::REQ_RES: begin
				res_c = opv_s1 & ~mask_c;
				we_c  = 1'b1;
			end
			cpu8asb_pkg::REQ_SET: begin
				res_c = opv_s1 | mask_c;
				we_c  = 1'b1;
			end
			cpu8asb_pkg::REQ_ROT_A: begin
				res_c  = rot_c[7:0];
				we_c   = 1'b1;
				zfix_c = 1'b0;
				n_c    = 1'b0;
				h_c    = 1'b0;
				c_c    = rot_c[8];
			end
			cpu8asb_pkg::REQ_MISC: begin
				case (cpu8asb_pkg::misc_op_t'(sub_s1))
					cpu8asb_pkg::MISC_CPL: begin
						res_c = ~acc_s1;
						we_c  = 1'b1;
						n_c   = 1'b1;
						h_c   = 1'b1;
					end
					cpu8asb_pkg::MISC_SCF: begin
						n_c = 1'b0;
						h_c = 1'b0;
						c_c = 1'b1;
					end
					cpu8asb_pkg::MISC_CCF: begin
						n_c = 1'b0;
						h_c = 1'b0;
						c_c = ~cin_c;
					end
					default: begin
						// unused code: no operation
					end
				endcase
			end
			default: begin
				// unused group: no operation
			end
		endcase
	end

	logic       vld_s2;
	logic [7:0] res_s2;
	logic       we_s2;
	logic       n_s2;
	logic       h_s2;
	logic       c_s2;
	logic [7:0] ztest_s2;
	logic       zuse_s2;
	logic       zfix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2   <= res_c;
			we_s2    <= we_c;
			n_s2     <= n_c;
			h_s2     <= h_c;
			c_s2     <= c_c;
			ztest_s2 <= ztest_c;
			zuse_s2  <= zuse_c;
			zfix_s2  <= zfix_c;
		end
	end

	// ---------------- stage 3: zero flag and output register ----------------
	logic       vld_s3;
	logic [7:0] res_s3;
	logic       we_s3;
	logic [3:0] fl_s3;
	logic       z_c;

	assign z_c = zuse_s2 ? (ztest_s2 == 8'd0) : zfix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			res_s3 <= res_s2;
			we_s3  <= we_s2;
			fl_s3  <= {z_c, n_s2, h_s2, c_s2};
		end
	end

	assign done         = vld_s3;
	assign result_value = res_s3;
	assign write_enable = we_s3;
	assign flags_out    = fl_s3;

endmodule

FILE: sim/cpu8_alu_shift_bit_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_shift_bit_unit_tb: self-checking bench for the ALU, shift and bit unit
// Directed corner words, then random words under several sender idle rates.
// Expected results come from an in-bench model of the flag rules and are
// compared in order with every done strobe.
// ----------------------------------------------------------------------------
module cpu8_alu_shift_bit_unit_tb;

	// codes outside the enums of the package: spare group, spare flag op
	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam logic [2:0] MISC_NONE  = 3'd3;
	localparam int unsigned MAX_REPORTS = 10;

	// one input word and one result word, at the port widths
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] sub;
		logic [7:0] acc;
		logic [7:0] opnd;
		logic [3:0] flags;
	} alu_word_t;

	typedef struct packed {
		logic [7:0] value;
		logic       wr;
		logic [3:0] flags;
	} alu_result_t;

	// -------------------------------------------------------------------------
	// Scoreboard: predicts each accepted word and checks results in order
	// -------------------------------------------------------------------------
	class alu_scoreboard;
		alu_result_t outcomes_due[$];
		int unsigned errors = 0;

		// {carry out, byte} for the prefixed shifts and accumulator rotates
		function logic [8:0] shift_result(logic [2:0] kind, logic [7:0] v, logic cin);
			logic [7:0] b;
			logic c;
			case (kind)
				cpu8asb_pkg::SH_RLC:  begin c = v[7]; b = (v << 1) | (v >> 7); end
				cpu8asb_pkg::SH_RRC:  begin c = v[0]; b = (v >> 1) | (v << 7); end
				cpu8asb_pkg::SH_RL:   begin c = v[7]; b = (v << 1) | {7'd0, cin}; end
				cpu8asb_pkg::SH_RR:   begin c = v[0]; b = (v >> 1) | {cin, 7'd0}; end
				cpu8asb_pkg::SH_SLA:  begin c = v[7]; b = v << 1; end
				cpu8asb_pkg::SH_SRA:  begin c = v[0]; b = (v >> 1) | (v & 8'h80); end
				cpu8asb_pkg::SH_SWAP: begin c = 1'b0; b = {v[3:0], v[7:4]}; end
				default: begin c = v[0]; b = v >> 1; end
			endcase
			return {c, b};
		endfunction

		function alu_result_t predict_outcome(alu_word_t w);
			alu_result_t r;
			logic cin, ci, n, h, c;
			logic [8:0] wide;
			logic [4:0] nib;
			logic [7:0] m;
			cin = w.flags[cpu8asb_pkg::FLAG_C];
			m = 8'h01 << w.sub;
			// default: no operation, accumulator echoed, flags kept
			r.value = w.acc;
			r.wr = 1'b0;
			r.flags = w.flags;
			case (w.kind)
				cpu8asb_pkg::REQ_ALU: begin
					n = 1'b0; h = 1'b0; c = 1'b0;
					case (w.sub)
						cpu8asb_pkg::ALU_ADD, cpu8asb_pkg::ALU_ADC: begin
							ci = (w.sub == cpu8asb_pkg::ALU_ADC) && cin;
							wide = {1'b0, w.acc} + {1'b0, w.opnd} + {8'd0, ci};
							nib = {1'b0, w.acc[3:0]} + {1'b0, w.opnd[3:0]} + {4'd0, ci};
							h = nib[4];
							c = wide[8];
							r.value = wide[7:0];
						end
						cpu8asb_pkg::ALU_SUB, cpu8asb_pkg::ALU_SBC,
						cpu8asb_pkg::ALU_CP: begin
							// borrow shows as the sign of the wider difference
							ci = (w.sub == cpu8asb_pkg::ALU_SBC) && cin;
							wide = {1'b0, w.acc} - {1'b0, w.opnd} - {8'd0, ci};
							nib = {1'b0, w.acc[3:0]} - {1'b0, w.opnd[3:0]} - {4'd0, ci};
							h = nib[4];
							c = wide[8];
							n = 1'b1;
							r.value = wide[7:0];
						end
						cpu8asb_pkg::ALU_AND: begin r.value = w.acc & w.opnd; h = 1'b1; end
						cpu8asb_pkg::ALU_XOR: r.value = w.acc ^ w.opnd;
						default: r.value = w.acc | w.opnd;
					endcase
					r.flags = {r.value == 8'h00, n, h, c};
					r.wr = (w.sub != cpu8asb_pkg::ALU_CP);
					if (w.sub == cpu8asb_pkg::ALU_CP)
						r.value = w.acc;
				end
				cpu8asb_pkg::REQ_SHIFT: begin
					{c, r.value} = shift_result(w.sub, w.opnd, cin);
					r.flags = {r.value == 8'h00, 2'b00, c};
					r.wr = 1'b1;
				end
				cpu8asb_pkg::REQ_BIT: begin
					r.value = w.opnd;
					r.flags = {~|(w.opnd & m), 1'b0, 1'b1, cin};
				end
				cpu8asb_pkg::REQ_RES: begin r.value = w.opnd & ~m; r.wr = 1'b1; end
				cpu8asb_pkg::REQ_SET: begin r.value = w.opnd | m; r.wr = 1'b1; end
				cpu8asb_pkg::REQ_ROT_A: begin
					// low two bits pick the kind; Z is always cleared
					{c, r.value} = shift_result({1'b0, w.sub[1:0]}, w.acc, cin);
					r.flags = {3'b000, c};
					r.wr = 1'b1;
				end
				cpu8asb_pkg::REQ_MISC: begin
					case (w.sub)
						cpu8asb_pkg::MISC_CPL: begin
							r.value = ~w.acc;
							r.wr = 1'b1;
							r.flags[cpu8asb_pkg::FLAG_N] = 1'b1;
							r.flags[cpu8asb_pkg::FLAG_H] = 1'b1;
						end
						cpu8asb_pkg::MISC_SCF:
							r.flags = {w.flags[cpu8asb_pkg::FLAG_Z], 2'b00, 1'b1};
						cpu8asb_pkg::MISC_CCF:
							r.flags = {w.flags[cpu8asb_pkg::FLAG_Z], 2'b00, ~cin};
						default: ;
					endcase
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_word(alu_word_t w);
			outcomes_due.push_back(predict_outcome(w));
		endfunction

		function void report(string what, alu_result_t exp, alu_result_t got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display({"%0t: %s: expected value %02h we %0b flags %04b, ",
					"got value %02h we %0b flags %04b"},
					$time, what, exp.value, exp.wr, exp.flags, got.value, got.wr, got.flags);
		endfunction

		function void check_word(alu_result_t got);
			alu_result_t exp;
			if (outcomes_due.size() == 0) begin
				report("result with nothing pending", '0, got);
			end else begin
				exp = outcomes_due.pop_front();
				if (got.value !== exp.value || got.wr !== exp.wr || got.flags !== exp.flags)
					report("result mismatch", exp, got);
			end
		endfunction
	endclass

	// -------------------------------------------------------------------------
	// Clock, reset and the DUT
	// -------------------------------------------------------------------------
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [2:0] req_type = '0;
	logic [2:0] sub_op = '0;
	logic [7:0] acc_value = '0;
	logic [7:0] operand_value = '0;
	logic [3:0] flags_in = '0;
	logic       done;
	logic [7:0] result_value;
	logic       write_enable;
	logic [3:0] flags_out;

	alu_scoreboard sb = new();

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cpu8_alu_shift_bit_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.sub_op        (sub_op),
		.acc_value     (acc_value),
		.operand_value (operand_value),
		.flags_in      (flags_in),
		.done          (done),
		.result_value  (result_value),
		.write_enable  (write_enable),
		.flags_out     (flags_out)
	);

	// Monitor: everything is sampled at the edge, before the NBA updates land,
	// so it sees exactly what the DUT saw. A result strobe cannot belong to a
	// word taken at the same edge, so the order of the two steps is free.
	always @(posedge clk) begin
		if (done)
			sb.check_word(alu_result_t'({result_value, write_enable, flags_out}));
		if (start && !busy)
			sb.note_word(alu_word_t'({req_type, sub_op, acc_value, operand_value, flags_in}));
	end

	// -------------------------------------------------------------------------
	// Stimulus helpers
	// -------------------------------------------------------------------------
	function automatic alu_word_t word_of(logic [2:0] k, logic [2:0] s, logic [7:0] a,
		logic [7:0] o, logic [3:0] f);
		alu_word_t w;
		w = {k, s, a, o, f};
		return w;
	endfunction

	// biased towards the nibble and sign boundaries
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h0F;
			3: return 8'hF0;
			4: return 8'h80;
			5: return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly real groups; the spare group and spare flag ops now and then
	function automatic alu_word_t pick_word();
		alu_word_t w;
		w.kind = ($urandom_range(39) == 0) ? REQ_UNUSED : 3'($urandom_range(6));
		w.sub = 3'($urandom);
		if (w.kind == cpu8asb_pkg::REQ_MISC && $urandom_range(3) != 0)
			w.sub = 3'($urandom_range(2));
		w.acc = pick_byte();
		w.opnd = pick_byte();
		w.flags = 4'($urandom);
		return w;
	endfunction

	// Idle for a random number of cycles (junk on the fields while start is
	// low), then present the word and hold it until it is taken.
	task automatic send_word(input alu_word_t w, input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			req_type <= 3'($urandom);
			sub_op <= 3'($urandom);
			acc_value <= 8'($urandom);
			operand_value <= 8'($urandom);
			flags_in <= 4'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		{req_type, sub_op, acc_value, operand_value, flags_in} <= w;
		do
			@(posedge clk);
		while (busy);
	endtask

	// hold off until every pending result has been seen
	task automatic drain();
		start <= 1'b0;
		while (sb.outcomes_due.size() != 0)
			@(posedge clk);
	endtask

	// -------------------------------------------------------------------------
	// Main sequence
	// -------------------------------------------------------------------------
	int unsigned idle_plan[3] = '{0, 79, 31};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ALU corners: full carry to zero, half carry via adc, equal sub,
		// sbc borrow from zero, and/xor/or zero results, cp with half borrow
		send_word(word_of(cpu8asb_pkg::REQ_ALU, cpu8asb_pkg::ALU_ADD, 8'hFF, 8'h01, 4'h0), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ALU, cpu8asb_pkg::ALU_ADC, 8'h0F, 8'h00, 4'h1), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ALU, cpu8asb_pkg::ALU_SUB, 8'h3C, 8'h3C, 4'h0), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ALU, cpu8asb_pkg::ALU_SBC, 8'h00, 8'hFF, 4'hF), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ALU, cpu8asb_pkg::ALU_AND, 8'hF0, 8'h0F, 4'h0), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ALU, cpu8asb_pkg::ALU_XOR, 8'hFF, 8'hFF, 4'hF), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ALU, cpu8asb_pkg::ALU_OR, 8'h00, 8'h00, 4'hF), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ALU, cpu8asb_pkg::ALU_CP, 8'h10, 8'h01, 4'h0), 0);
		// every shift kind, edge bits set and carry in high
		for (int k = 0; k < 8; k++)
			send_word(word_of(cpu8asb_pkg::REQ_SHIFT, 3'(k), 8'h00,
				(k % 2) ? 8'h01 : 8'h80, 4'h1), 0);
		// bit test on top and bottom bit, reset and set
		send_word(word_of(cpu8asb_pkg::REQ_BIT, 3'd7, 8'h00, 8'h7F, 4'h0), 0);
		send_word(word_of(cpu8asb_pkg::REQ_BIT, 3'd0, 8'h00, 8'hFF, 4'hF), 0);
		send_word(word_of(cpu8asb_pkg::REQ_RES, 3'd7, 8'h00, 8'hFF, 4'h5), 0);
		send_word(word_of(cpu8asb_pkg::REQ_SET, 3'd0, 8'h00, 8'h00, 4'hA), 0);
		// accumulator rotates; upper codes fold onto rla/rra, Z stays clear
		send_word(word_of(cpu8asb_pkg::REQ_ROT_A, cpu8asb_pkg::SH_RLC, 8'h80, 8'h00, 4'h8), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ROT_A, cpu8asb_pkg::SH_RRC, 8'h01, 8'h00, 4'h0), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ROT_A, cpu8asb_pkg::SH_SWAP, 8'h80, 8'h00, 4'h0), 0);
		send_word(word_of(cpu8asb_pkg::REQ_ROT_A, cpu8asb_pkg::SH_SRL, 8'h01, 8'h00, 4'h1), 0);
		// cpl/scf/ccf, a spare flag op and the spare group
		send_word(word_of(cpu8asb_pkg::REQ_MISC, cpu8asb_pkg::MISC_CPL, 8'h5A, 8'h00, 4'h9), 0);
		send_word(word_of(cpu8asb_pkg::REQ_MISC, cpu8asb_pkg::MISC_SCF, 8'h33, 8'h00, 4'h8), 0);
		send_word(word_of(cpu8asb_pkg::REQ_MISC, cpu8asb_pkg::MISC_CCF, 8'h33, 8'h00, 4'h1), 0);
		send_word(word_of(cpu8asb_pkg::REQ_MISC, MISC_NONE, 8'hC3, 8'h00, 4'h6), 0);
		send_word(word_of(REQ_UNUSED, 3'd0, 8'hA5, 8'h5A, 4'hB), 0);

		// let the pipe empty completely once before the random part
		drain();

		foreach (idle_plan[p])
			repeat (100) send_word(pick_word(), idle_plan[p]);
		// closing stretch back to back
		repeat (100) send_word(pick_word(), 0);

		drain();
		// a few more cycles to catch stray strobes
		repeat (8) @(posedge clk);

		if (sb.outcomes_due.size() != 0)
			sb.report("result never arrived", sb.outcomes_due[0], '0);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
